// ===== src/rrt_pkg.sv =====
`default_nettype none

package rrt_pkg;

    // Operation codes carried in the op field
    localparam logic OP_ACCEPT = 1'b0;
    localparam logic OP_MARK   = 1'b1;

    // Verdict codes (accept: accepted/duplicate/refused, mark: inserted/refreshed/full)
    localparam logic [1:0] VERDICT_NEW     = 2'd0;
    localparam logic [1:0] VERDICT_KNOWN   = 2'd1;
    localparam logic [1:0] VERDICT_REFUSED = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_TTL  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SKEW = 1'd1;

    // Configuration reset values
    localparam logic [31:0] TTL_RESET  = 32'd300;
    localparam logic [31:0] SKEW_RESET = 32'd30;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_RESULT
    } t_state;

    // Outcome flags of one pass over the table
    typedef struct packed {
        logic hit;
        logic free;
    } t_scan_flags;

endpackage

`default_nettype wire

// ===== src/rrt_table.sv =====
`default_nettype none

module rrt_table
    import rrt_pkg::*;
#(
    parameter int unsigned SLOTS = 16,
    parameter int unsigned IDX_W = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [IDX_W-1:0] i_rd_idx,
    output logic                  o_rd_valid,
    output logic [31:0]           o_rd_source,
    output logic [63:0]           o_rd_counter,
    output logic [31:0]           o_rd_seen,
    input  wire logic             i_wr_en,
    input  wire logic [IDX_W-1:0] i_wr_idx,
    input  wire logic [31:0]      i_wr_source,
    input  wire logic [63:0]      i_wr_counter,
    input  wire logic [31:0]      i_wr_seen
);

    logic [SLOTS-1:0] r_valid;
    logic [31:0]      r_mem_source  [SLOTS];
    logic [63:0]      r_mem_counter [SLOTS];
    logic [31:0]      r_mem_seen    [SLOTS];

    // Mark slots occupied; reset frees every slot at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_idx] <= 1'b1;
        end
    end

    // Write the record payload
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_source[i_wr_idx]  <= i_wr_source;
            r_mem_counter[i_wr_idx] <= i_wr_counter;
            r_mem_seen[i_wr_idx]    <= i_wr_seen;
        end
    end

    // Registered read of one slot per cycle
    always_ff @(posedge i_clk) begin
        o_rd_valid   <= r_valid[i_rd_idx];
        o_rd_source  <= r_mem_source[i_rd_idx];
        o_rd_counter <= r_mem_counter[i_rd_idx];
        o_rd_seen    <= r_mem_seen[i_rd_idx];
    end

endmodule

`default_nettype wire

// ===== src/rrt_scan.sv =====
`default_nettype none

module rrt_scan
    import rrt_pkg::*;
#(
    parameter int unsigned IDX_W = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic             i_step,
    input  wire logic [IDX_W-1:0] i_idx,
    input  wire logic             i_slot_valid,
    input  wire logic [31:0]      i_slot_source,
    input  wire logic [63:0]      i_slot_counter,
    input  wire logic [31:0]      i_slot_seen,
    input  wire logic [31:0]      i_key_source,
    input  wire logic [63:0]      i_key_counter,
    input  wire logic [31:0]      i_now,
    output t_scan_flags           o_flags,
    output logic [IDX_W-1:0]      o_match_idx,
    output logic [IDX_W-1:0]      o_free_idx,
    output logic [IDX_W-1:0]      o_old_idx,
    output logic [31:0]           o_old_age
);

    t_scan_flags      r_flags;
    logic             r_first;
    logic [IDX_W-1:0] r_match_idx;
    logic [IDX_W-1:0] r_free_idx;
    logic [IDX_W-1:0] r_old_idx;
    logic [31:0]      r_old_age;
    logic [31:0]      w_age;
    logic             w_match;

    // Modular age of the slot under test and key compare
    assign w_age   = i_now - i_slot_seen;
    assign w_match = i_slot_valid && (i_slot_source == i_key_source)
                     && (i_slot_counter == i_key_counter);

    // Track first match and first free slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_first <= 1'b1;
        end else if (i_start) begin
            r_flags <= '0;
            r_first <= 1'b1;
        end else if (i_step) begin
            r_first <= 1'b0;
            if (w_match && !r_flags.hit) begin
                r_flags.hit <= 1'b1;
            end
            if (!i_slot_valid && !r_flags.free) begin
                r_flags.free <= 1'b1;
            end
        end
    end

    // Hold indexes and the oldest age; strict compare keeps the first slot on ties
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            if (w_match && !r_flags.hit) begin
                r_match_idx <= i_idx;
            end
            if (!i_slot_valid && !r_flags.free) begin
                r_free_idx <= i_idx;
            end
            if (r_first || (w_age > r_old_age)) begin
                r_old_age <= w_age;
                r_old_idx <= i_idx;
            end
        end
    end

    assign o_flags     = r_flags;
    assign o_match_idx = r_match_idx;
    assign o_free_idx  = r_free_idx;
    assign o_old_idx   = r_old_idx;
    assign o_old_age   = r_old_age;

endmodule

`default_nettype wire

// ===== src/replay_record_table_ttl.sv =====
`default_nettype none

// Replay record table with time-to-live. Each transferred item runs one operation against
// a table of SLOTS records: accept (timing check, duplicate check, record) or mark-seen
// (refresh or insert). A sequencer walks the table one slot per cycle through a single
// registered read port and one shared compare/age unit; an item goes through the check,
// scan, drain, decide and result states (an accept that fails the timing check goes from
// check straight to result), and the next item may transfer in the cycle after the result
// is loaded into the output register. The input side stalls while an item is in work.
// Configuration writes take effect at once and are meant for idle periods.
module replay_record_table_ttl
    import rrt_pkg::*;
#(
    parameter int unsigned SLOTS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Input channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_op,
    input  wire logic [31:0]          i_source_id,
    input  wire logic [63:0]          i_msg_counter,
    input  wire logic [31:0]          i_sent_time,
    input  wire logic [31:0]          i_now_time,
    input  wire logic                 i_sync_ok,
    // Result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [1:0]                o_verdict,
    output logic [31:0]               o_eviction_count,
    output logic [31:0]               o_denied_count,
    // Configuration
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]          i_cfg_data
);

    localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    t_state           r_state;
    t_state           n_state;
    logic [31:0]      r_ttl;
    logic [31:0]      r_skew;
    logic             r_op;
    logic [31:0]      r_source;
    logic [63:0]      r_counter;
    logic [31:0]      r_sent;
    logic [31:0]      r_now;
    logic             r_sync;
    logic [IDX_W-1:0] r_cnt;
    logic             r_step;
    logic [IDX_W-1:0] r_step_idx;
    logic [1:0]       r_verdict;
    logic [1:0]       n_verdict;
    logic [31:0]      r_evictions;
    logic [31:0]      r_refusals;
    logic             r_out_valid;
    logic [1:0]       r_out_verdict;
    logic [31:0]      r_out_evictions;
    logic [31:0]      r_out_refusals;

    logic             w_in_xfer;
    logic             w_out_xfer;
    logic             w_reject;
    logic [31:0]      w_limit;
    logic [31:0]      w_lag;
    logic             w_scan_start;
    logic             w_set_verdict;
    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_idx;
    logic             w_evict;
    logic             w_refuse;
    logic             w_load_out;

    logic             w_rd_valid;
    logic [31:0]      w_rd_source;
    logic [63:0]      w_rd_counter;
    logic [31:0]      w_rd_seen;
    t_scan_flags      w_flags;
    logic [IDX_W-1:0] w_match_idx;
    logic [IDX_W-1:0] w_free_idx;
    logic [IDX_W-1:0] w_old_idx;
    logic [31:0]      w_old_age;

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_xfer = r_out_valid && !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Timing check of an accept: missing sync, send time in the future, or too old
    assign w_limit  = r_now + r_skew;
    assign w_lag    = r_now - r_sent;
    assign w_reject = (r_op == OP_ACCEPT)
                      && (!r_sync || (r_sent > w_limit)
                          || ((r_now > r_sent) && (w_lag > r_ttl)));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = w_reject ? S_RESULT : S_SCAN;
            end
            S_SCAN: begin
                if (r_cnt == LAST_IDX) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        w_scan_start  = 1'b0;
        w_set_verdict = 1'b0;
        n_verdict     = VERDICT_REFUSED;
        w_wr_en       = 1'b0;
        w_wr_idx      = w_free_idx;
        w_evict       = 1'b0;
        w_refuse      = 1'b0;
        w_load_out    = 1'b0;
        case (r_state)
            S_CHECK: begin
                if (w_reject) begin
                    w_set_verdict = 1'b1;
                end else begin
                    w_scan_start = 1'b1;
                end
            end
            S_DECIDE: begin
                w_set_verdict = 1'b1;
                if (w_flags.hit) begin
                    n_verdict = VERDICT_KNOWN;
                    w_wr_idx  = w_match_idx;
                    w_wr_en   = (r_op == OP_MARK);
                end else if (w_flags.free) begin
                    n_verdict = VERDICT_NEW;
                    w_wr_en   = 1'b1;
                end else if (w_old_age > r_ttl) begin
                    n_verdict = VERDICT_NEW;
                    w_wr_idx  = w_old_idx;
                    w_wr_en   = 1'b1;
                    w_evict   = 1'b1;
                end else begin
                    w_refuse = 1'b1;
                end
            end
            S_RESULT: begin
                w_load_out = !r_out_valid || !i_out_stall;
            end
            default: begin
            end
        endcase
    end

    // State and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ttl   <= TTL_RESET;
            r_skew  <= SKEW_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TTL:  r_ttl  <= i_cfg_data;
                    REG_SKEW: r_skew <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Capture the item on its transfer
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_op      <= i_op;
            r_source  <= i_source_id;
            r_counter <= i_msg_counter;
            r_sent    <= i_sent_time;
            r_now     <= i_now_time;
            r_sync    <= i_sync_ok;
        end
    end

    // Advance the slot address; the step flag trails it by the read latency
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 1'b0;
        end else begin
            r_step <= (r_state == S_SCAN);
        end
        if (w_scan_start) begin
            r_cnt <= '0;
        end else if (r_state == S_SCAN) begin
            r_cnt <= r_cnt + 1'b1;
        end
        r_step_idx <= r_cnt;
        if (w_set_verdict) begin
            r_verdict <= n_verdict;
        end
    end

    // Wrapping eviction and refusal counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_evictions <= '0;
            r_refusals  <= '0;
        end else begin
            if (w_evict) begin
                r_evictions <= r_evictions + 32'd1;
            end
            if (w_refuse) begin
                r_refusals <= r_refusals + 32'd1;
            end
        end
    end

    // Output register: load a result, drop it on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (w_out_xfer) begin
            r_out_valid <= 1'b0;
        end
        if (w_load_out) begin
            r_out_verdict   <= r_verdict;
            r_out_evictions <= r_evictions;
            r_out_refusals  <= r_refusals;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_verdict        = r_out_verdict;
    assign o_eviction_count = r_out_evictions;
    assign o_denied_count   = r_out_refusals;

    rrt_table #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_idx     (r_cnt),
        .o_rd_valid   (w_rd_valid),
        .o_rd_source  (w_rd_source),
        .o_rd_counter (w_rd_counter),
        .o_rd_seen    (w_rd_seen),
        .i_wr_en      (w_wr_en),
        .i_wr_idx     (w_wr_idx),
        .i_wr_source  (r_source),
        .i_wr_counter (r_counter),
        .i_wr_seen    (r_now)
    );

    rrt_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_scan_start),
        .i_step         (r_step),
        .i_idx          (r_step_idx),
        .i_slot_valid   (w_rd_valid),
        .i_slot_source  (w_rd_source),
        .i_slot_counter (w_rd_counter),
        .i_slot_seen    (w_rd_seen),
        .i_key_source   (r_source),
        .i_key_counter  (r_counter),
        .i_now          (r_now),
        .o_flags        (w_flags),
        .o_match_idx    (w_match_idx),
        .o_free_idx     (w_free_idx),
        .o_old_idx      (w_old_idx),
        .o_old_age      (w_old_age)
    );

    // A table write and a refusal never come from the same decision
    a_write_or_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_wr_en && w_refuse))
        else $error("table write and refusal in the same cycle");

    // An input transfer starts the timing check in the next cycle
    a_xfer_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == S_CHECK))
        else $error("input transfer not followed by check");

    // The eviction counter moves only out of the decision step
    a_evict_from_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_evictions != $past(r_evictions)))
            |-> ($past(r_state) == S_DECIDE))
        else $error("eviction count changed outside decision");

    // A result appears only from the result state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_RESULT))
        else $error("result offered outside result state");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import rrt_pkg::*;

    localparam int SLOTS       = 16;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic        op;
        logic [31:0] source;
        logic [63:0] counter;
        logic [31:0] sent;
        logic [31:0] now;
        logic        sync;
    } t_msg;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [31:0] evictions;
        logic [31:0] refusals;
    } t_outcome;

    // Clock, reset and block inputs, all known from time zero
    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_op      = OP_ACCEPT;
    logic [31:0]          in_source  = '0;
    logic [63:0]          in_counter = '0;
    logic [31:0]          in_sent    = '0;
    logic [31:0]          in_now     = '0;
    logic                 in_sync    = 1'b0;
    logic                 out_stall  = 1'b0;
    logic                 cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx    = REG_TTL;
    logic [31:0]          cfg_data   = '0;

    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [1:0]           o_verdict;
    logic [31:0]          o_eviction_count;
    logic [31:0]          o_denied_count;

    // Shadow of the record table and its registers
    logic                 rec_valid [SLOTS];
    logic [31:0]          rec_source [SLOTS];
    logic [63:0]          rec_counter [SLOTS];
    logic [31:0]          rec_seen [SLOTS];
    logic [31:0]          evict_total;
    logic [31:0]          deny_total;
    logic [31:0]          ttl_cfg;
    logic [31:0]          skew_cfg;

    t_msg                 pending_msgs [$];
    t_outcome             expected_verdicts [$];
    t_msg                 next_msg;
    t_outcome             want;
    logic [31:0]          clock_now = 32'd0;

    logic                 in_fire    = 1'b0;
    logic                 out_fire   = 1'b0;
    bit                   send_burst = 1'b0;
    bit                   recv_burst = 1'b0;
    int                   send_gap   = 0;
    int                   recv_gap   = 0;
    int                   hold_left  = 0;
    int                   next_hold  = 150;
    int                   n_queued   = 0;
    int                   n_out      = 0;
    int                   fail_count = 0;
    int                   cycle_count = 0;

    replay_record_table_ttl #(
        .SLOTS(SLOTS)
    ) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (in_op),
        .i_source_id     (in_source),
        .i_msg_counter   (in_counter),
        .i_sent_time     (in_sent),
        .i_now_time      (in_now),
        .i_sync_ok       (in_sync),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_verdict       (o_verdict),
        .o_eviction_count(o_eviction_count),
        .o_denied_count  (o_denied_count),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic int draw_wait(input bit burst);
        return burst ? 0 : int'($urandom_range(0, 17));
    endfunction

    // Run one message against the shadow table and queue the verdict it earns
    task automatic judge_item(input t_msg m);
        logic [31:0] limit;
        logic [31:0] age_k;
        logic [31:0] age_old;
        int          hit;
        int          slot;
        int          oldest;
        t_outcome    res;
        limit = m.now + skew_cfg;
        hit = -1;
        for (int k = 0; k < SLOTS; k++) begin
            if (hit < 0 && rec_valid[k] && rec_source[k] == m.source &&
                rec_counter[k] == m.counter) begin
                hit = k;
            end
        end
        if (m.op == OP_ACCEPT && (!m.sync || m.sent > limit ||
            (m.now > m.sent && (m.now - m.sent) > ttl_cfg))) begin
            res.verdict = VERDICT_REFUSED;
        end else if (hit >= 0) begin
            if (m.op == OP_MARK) begin
                rec_seen[hit] = m.now;
            end
            res.verdict = VERDICT_KNOWN;
        end else begin
            // first free slot wins; otherwise the oldest record, if past the TTL
            slot = -1;
            for (int k = 0; k < SLOTS; k++) begin
                if (slot < 0 && !rec_valid[k]) begin
                    slot = k;
                end
            end
            if (slot < 0) begin
                oldest = 0;
                for (int k = 1; k < SLOTS; k++) begin
                    age_k   = m.now - rec_seen[k];
                    age_old = m.now - rec_seen[oldest];
                    if (age_k > age_old) begin
                        oldest = k;
                    end
                end
                age_old = m.now - rec_seen[oldest];
                if (age_old > ttl_cfg) begin
                    evict_total = evict_total + 32'd1;
                    slot = oldest;
                end else begin
                    deny_total = deny_total + 32'd1;
                end
            end
            if (slot < 0) begin
                res.verdict = VERDICT_REFUSED;
            end else begin
                rec_valid[slot]   = 1'b1;
                rec_source[slot]  = m.source;
                rec_counter[slot] = m.counter;
                rec_seen[slot]    = m.now;
                res.verdict = VERDICT_NEW;
            end
        end
        res.evictions = evict_total;
        res.refusals  = deny_total;
        expected_verdicts.push_back(res);
    endtask

    task automatic queue_msg(input logic op, input logic [31:0] source,
                             input logic [63:0] counter, input logic [31:0] sent,
                             input logic [31:0] now, input logic sync);
        t_msg m;
        m = '{op, source, counter, sent, now, sync};
        pending_msgs.push_back(m);
        n_queued++;
    endtask

    // Wait until every queued message has produced its result, then let the block go quiet
    task automatic settle();
        while (n_out != n_queued) begin
            @(negedge clk);
        end
        repeat (SLOTS + 8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_TTL) begin
            ttl_cfg = value;
        end else begin
            skew_cfg = value;
        end
    endtask

    // Mostly pooled keys on an advancing clock, so duplicates, refreshes, evictions and
    // refusals all recur; a few messages are pure noise across every bit
    task automatic run_phase(input logic [31:0] ttl, input logic [31:0] skew, input int count,
                             input int unsigned step_max, input int unsigned win);
        t_msg m;
        write_reg(REG_TTL, ttl);
        write_reg(REG_SKEW, skew);
        for (int n = 0; n < count; n++) begin
            m.op = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 8) begin
                m.source  = $urandom;
                m.counter = {$urandom, $urandom};
                m.sent    = $urandom;
                m.now     = $urandom;
                m.sync    = 1'($urandom_range(0, 1));
            end else begin
                clock_now = clock_now + $urandom_range(0, step_max);
                m.now     = clock_now;
                m.source  = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 5);
                m.counter = ($urandom_range(0, 5) == 0) ? {$urandom, $urandom}
                                                        : 64'($urandom_range(0, 5));
                if ($urandom_range(0, 3) != 0) begin
                    m.sent = m.now - $urandom_range(0, win / 2);
                end else begin
                    m.sent = m.now - win + $urandom_range(0, 2 * win);
                end
                m.sync = ($urandom_range(0, 15) != 0);
            end
            queue_msg(m.op, m.source, m.counter, m.sent, m.now, m.sync);
        end
        settle();
    endtask

    // Sender: present the next message after a random gap, hold it until the transfer
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_fire) begin
                if ($urandom_range(0, 29) == 0) begin
                    send_burst = !send_burst;
                end
                send_gap = draw_wait(send_burst);
            end
            if (!in_valid || in_fire) begin
                if (send_gap == 0 && pending_msgs.size() != 0) begin
                    next_msg = pending_msgs.pop_front();
                    in_valid   <= 1'b1;
                    in_op      <= next_msg.op;
                    in_source  <= next_msg.source;
                    in_counter <= next_msg.counter;
                    in_sent    <= next_msg.sent;
                    in_now     <= next_msg.now;
                    in_sync    <= next_msg.sync;
                end else begin
                    if (send_gap != 0) begin
                        send_gap--;
                    end
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall each result a random number of cycles, or for a long hold-off
    always @(negedge clk) begin
        if (out_fire) begin
            if ($urandom_range(0, 29) == 0) begin
                recv_burst = !recv_burst;
            end
            recv_gap = draw_wait(recv_burst);
        end
        if (hold_left != 0) begin
            out_stall <= 1'b1;
        end else if (recv_gap != 0 && o_out_valid === 1'b1) begin
            recv_gap--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Long hold-off while the sender keeps offering, so the block backs up its input
    always @(negedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (n_out >= next_hold && in_valid) begin
            hold_left <= 400;
            next_hold <= next_hold + 450;
        end
    end

    // Monitor: predict on each input transfer, check each result transfer
    always @(posedge clk) begin
        in_fire  <= rst_n && in_valid && !o_in_stall;
        out_fire <= rst_n && o_out_valid && !out_stall;
        if (rst_n && in_valid && !o_in_stall) begin
            judge_item({in_op, in_source, in_counter, in_sent, in_now, in_sync});
        end
        if (rst_n && o_out_valid && !out_stall) begin
            n_out++;
            if (expected_verdicts.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected result: verdict %0d evictions %0d denied %0d",
                             o_verdict, o_eviction_count, o_denied_count);
                end
            end else begin
                want = expected_verdicts.pop_front();
                if (o_verdict !== want.verdict || o_eviction_count !== want.evictions ||
                    o_denied_count !== want.refusals) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display({"result %0d mismatch: verdict %0d/%0d evictions %0d/%0d",
                                  " denied %0d/%0d (exp/got)"},
                                 n_out, want.verdict, o_verdict, want.evictions,
                                 o_eviction_count, want.refusals, o_denied_count);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < SLOTS; k++) begin
            rec_valid[k]   = 1'b0;
            rec_source[k]  = '0;
            rec_counter[k] = '0;
            rec_seen[k]    = '0;
        end
        evict_total = '0;
        deny_total  = '0;
        ttl_cfg     = TTL_RESET;
        skew_cfg    = SKEW_RESET;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Timing checks at reset settings: no sync, future, skew edge, too old, TTL edge
        queue_msg(OP_ACCEPT, 32'd1, 64'd1, 32'd1000, 32'd1000, 1'b0);
        queue_msg(OP_ACCEPT, 32'd1, 64'd1, 32'd1031, 32'd1000, 1'b1);
        queue_msg(OP_ACCEPT, 32'd1, 64'd1, 32'd1030, 32'd1000, 1'b1);
        queue_msg(OP_ACCEPT, 32'd1, 64'd2, 32'd699, 32'd1000, 1'b1);
        queue_msg(OP_ACCEPT, 32'd1, 64'd2, 32'd700, 32'd1000, 1'b1);
        // Duplicate, refresh, and inserts at the field extremes
        queue_msg(OP_ACCEPT, 32'd1, 64'd1, 32'd1000, 32'd1001, 1'b1);
        queue_msg(OP_MARK, 32'd1, 64'd1, 32'd0, 32'd1010, 1'b1);
        queue_msg(OP_MARK, 32'd0, 64'd0, 32'hFFFF_FFFF, 32'd1020, 1'b0);
        queue_msg(OP_MARK, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'd1030, 1'b1);
        // Skew sum wrapping past zero makes a near-now message look like the future
        queue_msg(OP_ACCEPT, 32'd7, 64'd7, 32'hFFFF_FFF5, 32'hFFFF_FFF0, 1'b1);
        queue_msg(OP_ACCEPT, 32'd7, 64'd8, 32'hFFFF_FFF0, 32'h0000_0010, 1'b1);
        // Fill the table, then a refusal with everything fresh and an eviction once stale
        for (int k = 0; k < 12; k++) begin
            queue_msg(OP_MARK, 32'd100 + k, 64'(k), 32'd0, 32'd1040, 1'b1);
        end
        queue_msg(OP_MARK, 32'd200, 64'd0, 32'd0, 32'd1100, 1'b1);
        queue_msg(OP_ACCEPT, 32'd201, 64'd0, 32'd1400, 32'd1400, 1'b1);
        settle();

        clock_now = 32'd1400;
        run_phase(32'd20, 32'd5, 265, 6, 30);
        run_phase(32'd0, 32'd0, 265, 1, 2);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 265, 1000, 3000);
        clock_now = 32'hFFFF_FF00;
        run_phase(32'd100, 32'd10, 265, 40, 150);
        run_phase(TTL_RESET, SKEW_RESET, 265, 100, 450);

        if (fail_count == 0 && expected_verdicts.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
